// ----- hw/rtl/sttf_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and helpers for the sine tone generator
// no dependencies

package sttf_pkg;

  localparam int unsigned SINE_INDEX_BITS = 10;
  localparam int unsigned COUNT_BITS      = 16;
  localparam int unsigned QUARTER_BITS    = SINE_INDEX_BITS - 2;
  localparam int unsigned Z_SHIFT         = 30 - QUARTER_BITS;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DIVD_W     = 32;
  localparam int unsigned DIVS_W     = 16;

  // odd taylor coefficients of sin(pi/2*z), unsigned q2.30
  localparam logic [31:0] K1 = 32'd1686629713;
  localparam logic [31:0] K3 = 32'd693598668;
  localparam logic [31:0] K5 = 32'd85569306;
  localparam logic [31:0] K7 = 32'd5026995;
  localparam logic [31:0] K9 = 32'd172273;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP = 8'd0,
    REG_VOLUME     = 8'd1,
    REG_TOTAL      = 8'd2,
    REG_FADE       = 8'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ZSQ,
    ST_Z2,
    ST_HMUL,
    ST_HSUB,
    ST_ZP,
    ST_RND,
    ST_VN,
    ST_VM,
    ST_DIVI,
    ST_DIV,
    ST_FIN
  } tone_state_e;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  // coefficient subtracted from in horner step n
  function automatic logic [31:0] horner_coef(input logic [1:0] step);
    logic [31:0] c;
    case (step)
      2'd0:    c = K7;
      2'd1:    c = K5;
      2'd2:    c = K3;
      default: c = K1;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/sttf_if.sv -----
`timescale 1ns / 1ps
// valid/ready channel interfaces for the tone generator
// depends on nothing

interface sttf_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface sttf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               last;
  logic               finished;
  modport source (output valid, output sample, output last, output finished, input ready);
  modport sink (input valid, input sample, input last, input finished, output ready);
endinterface

// ----- hw/rtl/sttf_div.sv -----
`timescale 1ns / 1ps
// restoring serial divider, one quotient bit per cycle
// depends on sttf_pkg

module sttf_div import sttf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  div_req_t          req_i,
  output logic              done_o,
  output logic [DIVD_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVD_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIVS_W:0]   rem_q, rem_d;
  logic [DIVD_W-1:0] dvd_q, dvd_d;
  logic [DIVS_W-1:0] dvs_q, dvs_d;
  logic [DIVS_W:0]   rem_sh;
  logic [DIVS_W:0]   rem_sub;
  logic              fits;

  assign rem_sh  = {rem_q[DIVS_W-1:0], dvd_q[DIVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign fits    = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '1;
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? rem_sub : rem_sh;
      dvd_d = {dvd_q[DIVD_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

// ----- hw/rtl/sine_tone_with_linear_fade_top.sv -----
`timescale 1ns / 1ps
// sine tone generator with linear fade envelope, one sample word per input word
// each word passes the check, polynomial, volume and fade steps in turn; inside a fade
//   the serial divider dominates its time; an ended tone goes from check straight to the final step
// a new word is accepted only in idle, when the output register is free or being read, no overlap
// reset: config registers, sample count and phase clear to zero, output empty
// depends on sttf_pkg, sttf_if, sttf_div

module sine_tone_with_linear_fade_top import sttf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  sttf_in_if.sink               in_i,
  sttf_out_if.source            out_o
);

  // wide enough to compare count, total and fade at the 16-bit count width
  localparam int unsigned EW = 25;
  localparam logic [QUARTER_BITS:0] QN = {1'b1, {QUARTER_BITS{1'b0}}};
  localparam logic [EW-1:0] CMAX_E = EW'({COUNT_BITS{1'b1}});

  tone_state_e state_q, state_d;

  // configuration
  logic [31:0] phase_step_q;
  logic [14:0] volume_q;
  logic [15:0] total_q;
  logic [15:0] fade_q;

  // architectural state
  logic [COUNT_BITS-1:0] count_q;
  logic [31:0]           phase_q;

  // working registers
  logic [30:0] z_q, z2_q;
  logic [31:0] p_q;
  logic [63:0] prod_q;
  logic [1:0]  hstep_q;
  logic [14:0] mag_q;
  logic [15:0] num_q, den_q, quo_q;
  logic        div_en_q, neg_q, last_q, fin_q;

  // output register
  logic        out_vld_q;
  logic [15:0] out_smp_q;
  logic        out_last_q, out_fin_q;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_d;
  assign prod_d = 64'(mul_a) * 64'(mul_b);

  // ---- per-sample decode for the check step
  logic [SINE_INDEX_BITS-1:0] idx;
  logic [QUARTER_BITS:0]      kq;
  logic [30:0]                z_new;
  logic [EW-1:0]              s_e, tot_e, fade_e, left_e;
  logic                       fade_in, fade_out, tone_done, is_last;

  always_comb begin
    idx   = phase_q[31 -: SINE_INDEX_BITS];
    kq    = idx[QUARTER_BITS] ? (QN - {1'b0, idx[QUARTER_BITS-1:0]})
                              : {1'b0, idx[QUARTER_BITS-1:0]};
    z_new = 31'(kq) << Z_SHIFT;
    s_e   = EW'(count_q);
    fade_e = EW'(fade_q);
    tot_e = (EW'(total_q) < CMAX_E) ? EW'(total_q) : CMAX_E;
    left_e = tot_e - s_e;
    tone_done = s_e >= tot_e;
    is_last   = s_e == (tot_e - EW'(1));
    fade_in   = (fade_e != '0) && (s_e < fade_e);
    fade_out  = (fade_e != '0) && (fade_e <= tot_e) && (s_e >= (tot_e - fade_e));
  end

  // rounding of the polynomial to q1.15 with clamp
  logic [32:0] v_rnd;
  logic [14:0] mag_new;
  always_comb begin
    v_rnd   = 33'(prod_q[61:30]) + 33'(17'h4000);
    mag_new = (v_rnd[32:15] > 18'd32767) ? 15'h7fff : v_rnd[29:15];
  end

  // ---- divider
  div_req_t          div_req;
  logic              div_done;
  logic [DIVD_W-1:0] div_quo;

  sttf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // ---- sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_i.valid && in_i.ready) state_d = ST_CHECK;
      ST_CHECK: state_d = tone_done ? ST_FIN : ST_ZSQ;
      ST_ZSQ:   state_d = ST_Z2;
      ST_Z2:    state_d = ST_HMUL;
      ST_HMUL:  state_d = ST_HSUB;
      ST_HSUB:  state_d = (hstep_q == 2'd3) ? ST_ZP : ST_HMUL;
      ST_ZP:    state_d = ST_RND;
      ST_RND:   state_d = ST_VN;
      ST_VN:    state_d = ST_VM;
      ST_VM:    state_d = ST_DIVI;
      ST_DIVI:  state_d = div_en_q ? ST_DIV : ST_FIN;
      ST_DIV:   if (div_done) state_d = ST_FIN;
      ST_FIN:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // ---- sequencer: outputs (multiplier operands, divider start, ready)
  always_comb begin
    mul_a       = '0;
    mul_b       = '0;
    in_i.ready  = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = prod_q[46:15];
    div_req.divisor  = den_q;
    unique case (state_q)
      ST_IDLE: in_i.ready = !out_vld_q || out_o.ready;
      ST_ZSQ: begin
        mul_a = 32'(z_q);
        mul_b = 32'(z_q);
      end
      ST_HMUL: begin
        mul_a = 32'(z2_q);
        mul_b = p_q;
      end
      ST_ZP: begin
        mul_a = 32'(z_q);
        mul_b = p_q;
      end
      ST_VN: begin
        mul_a = 32'(volume_q);
        mul_b = 32'(num_q);
      end
      ST_VM: begin
        mul_a = prod_q[31:0];
        mul_b = 32'(mag_q);
      end
      ST_DIVI: div_req.start = div_en_q;
      default: ;
    endcase
  end

  // ---- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      phase_step_q <= '0;
      volume_q     <= '0;
      total_q      <= '0;
      fade_q       <= '0;
      count_q      <= '0;
      phase_q      <= '0;
      out_vld_q    <= 1'b0;
      hstep_q      <= '0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_PHASE_STEP: phase_step_q <= cfg_data_i;
          REG_VOLUME:     volume_q     <= cfg_data_i[14:0];
          REG_TOTAL:      total_q      <= cfg_data_i[15:0];
          REG_FADE:       fade_q       <= cfg_data_i[15:0];
          default: ;
        endcase
      end

      if (out_vld_q && out_o.ready) out_vld_q <= 1'b0;

      // restart clears count and phase before this word is worked on
      if (state_q == ST_IDLE && in_i.valid && in_i.ready && in_i.restart) begin
        count_q <= '0;
        phase_q <= '0;
      end

      if (state_q == ST_Z2) hstep_q <= '0;
      if (state_q == ST_HSUB) hstep_q <= hstep_q + 2'd1;

      if (state_q == ST_FIN) begin
        out_vld_q <= 1'b1;
        if (!fin_q) begin
          count_q <= count_q + COUNT_BITS'(1);
          phase_q <= phase_q + phase_step_q;
        end
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (state_q)
      ST_CHECK: begin
        z_q      <= z_new;
        neg_q    <= idx[SINE_INDEX_BITS-1];
        fin_q    <= tone_done;
        last_q   <= is_last;
        div_en_q <= fade_in || fade_out;
        num_q    <= fade_in ? s_e[15:0] : (fade_out ? left_e[15:0] : 16'd1);
        den_q    <= fade_q;
      end
      ST_Z2: begin
        z2_q <= prod_q[60:30];
        p_q  <= K9;
      end
      ST_HSUB: p_q <= horner_coef(hstep_q) - prod_q[61:30];
      ST_RND:  mag_q <= mag_new;
      // without a fade the quotient is the scaled product itself
      ST_DIVI: quo_q <= prod_q[30:15];
      ST_DIV:  if (div_done) quo_q <= div_quo[15:0];
      ST_FIN: begin
        out_smp_q  <= fin_q ? 16'd0 : (neg_q ? (16'd0 - quo_q) : quo_q);
        out_last_q <= fin_q ? 1'b0 : last_q;
        out_fin_q  <= fin_q;
      end
      default: ;
    endcase
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.sample   = out_smp_q;
  assign out_o.last     = out_last_q;
  assign out_o.finished = out_fin_q;

endmodule

// ----- verif/tb_sine_tone_with_linear_fade_top.sv -----
`timescale 1ns / 1ps
// self-checking bench for the sine tone generator: directed table, then randomized tones
// depends on sttf_pkg, sttf_if and the rtl top sine_tone_with_linear_fade_top

module tb_sine_tone_with_linear_fade_top;
  import sttf_pkg::*;

  localparam int unsigned CLK_PERIOD      = 10;
  localparam int unsigned RESET_CYCLES    = 8;
  // bound for the whole run, about 1400 words in total
  localparam int unsigned WATCHDOG_CYCLES = 600000;
  // settle time after the last word, covers the longest in-fade latency
  localparam int unsigned SETTLE_CYCLES   = 60;
  localparam int unsigned RANDOM_WORDS    = 1300;
  localparam int unsigned MAX_WAIT        = 18;

  // an index that decodes to no register, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd200;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
    logic               finished;
  } tone_word_t;

  typedef enum logic {
    ROW_REG,
    ROW_WORD
  } row_kind_e;

  // one line of the directed table: a register write or an input word,
  // the word optionally carrying a hand-written expectation
  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  restart;
    logic                  typed;
    tone_word_t            want;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 38;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  sttf_in_if  in_if ();
  sttf_out_if out_if ();

  sine_tone_with_linear_fade_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // bench copy of the generator: registers and running state
  logic [31:0]           tone_step  = '0;
  logic [14:0]           tone_vol   = '0;
  logic [15:0]           tone_len   = '0;
  logic [15:0]           tone_fade  = '0;
  logic [COUNT_BITS-1:0] tone_count = '0;
  logic [31:0]           tone_phase = '0;

  tone_word_t pending_samples [$];
  int unsigned mismatches = 0;
  bit quiet = 1'b0;   // both sides run without gaps while set

  dir_row_t dir_tab [DIR_ROWS];

  // quarter-wave sine value for k in 0..2^QUARTER_BITS, q1.15,
  // odd taylor series through z^9 evaluated by horner in q2.30
  function automatic logic [15:0] quarter_wave(input logic [QUARTER_BITS:0] k);
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] p;
    logic [63:0] v;
    z  = 64'(k) << Z_SHIFT;
    z2 = (z * z) >> 30;
    p  = 64'(K9);
    p  = 64'(K7) - ((z2 * p) >> 30);
    p  = 64'(K5) - ((z2 * p) >> 30);
    p  = 64'(K3) - ((z2 * p) >> 30);
    p  = 64'(K1) - ((z2 * p) >> 30);
    v  = (z * p) >> 30;
    v  = (v + 64'd16384) >> 15;
    if (v > 64'd32767) v = 64'd32767;
    return v[15:0];
  endfunction

  // register write as the block decodes it: bits above a register's width drop
  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_PHASE_STEP: tone_step = data;
      REG_VOLUME:     tone_vol  = data[14:0];
      REG_TOTAL:      tone_len  = data[15:0];
      REG_FADE:       tone_fade = data[15:0];
      default: ;
    endcase
  endfunction

  // next sample word for one input word, advances count and phase while the tone lasts
  function automatic tone_word_t next_tone_sample(input logic restart);
    tone_word_t                res;
    logic [31:0]               cap;
    logic [31:0]               eff_len;
    logic [31:0]               s;
    logic [SINE_INDEX_BITS-1:0] idx;
    logic [1:0]                quad;
    logic [QUARTER_BITS:0]     r;
    logic [QUARTER_BITS:0]     qn;
    logic [15:0]               mag;
    logic [31:0]               num;
    logic [31:0]               den;
    logic [63:0]               prod;
    cap     = (32'd1 << COUNT_BITS) - 32'd1;
    eff_len = (32'(tone_len) < cap) ? 32'(tone_len) : cap;
    if (restart) begin
      tone_count = '0;
      tone_phase = '0;
    end
    s = 32'(tone_count);
    // tone over: silent, count and phase hold
    if (s >= eff_len) begin
      res.sample   = '0;
      res.last     = 1'b0;
      res.finished = 1'b1;
      return res;
    end
    idx  = tone_phase[31 -: SINE_INDEX_BITS];
    quad = idx[SINE_INDEX_BITS-1 -: 2];
    r    = {1'b0, idx[QUARTER_BITS-1:0]};
    qn   = {1'b1, {QUARTER_BITS{1'b0}}};
    mag  = quarter_wave(quad[0] ? qn - r : r);
    // fade-in wins, fade-out only when the fade fits inside the tone
    num = 32'd1;
    den = 32'd1;
    if (tone_fade != 0 && s < 32'(tone_fade)) begin
      num = s;
      den = 32'(tone_fade);
    end else if (tone_fade != 0 && 32'(tone_fade) <= eff_len
                 && s >= eff_len - 32'(tone_fade)) begin
      num = eff_len - s;
      den = 32'(tone_fade);
    end
    prod = 64'(tone_vol) * 64'(num) * 64'(mag);
    prod = prod / (64'(den) << 15);
    // magnitude truncated first, then signed, so rounding is toward zero
    res.sample   = quad[1] ? -prod[15:0] : prod[15:0];
    res.last     = (s == eff_len - 32'd1);
    res.finished = 1'b0;
    tone_count   = tone_count + 1'b1;
    tone_phase   = tone_phase + tone_step;
    return res;
  endfunction

  // offer one input word after a random gap, queue its expectation on accept
  task automatic send_word(input logic restart, input logic typed, input tone_word_t want);
    int unsigned gap;
    tone_word_t  pred;
    gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid   = 1'b1;
    in_if.restart = restart;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    // the model always steps so its state tracks the block
    pred = next_tone_sample(restart);
    pending_samples.push_back(typed ? want : pred);
  endtask

  // stop offering words and hold until every expected sample word has come back
  task automatic drain;
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    apply_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // directed table
  // - words right after reset: zero length, so every word reports finished
  // - quarter-turn phase step at full volume walks zero, positive peak, zero and negative peak,
  //   ending with last, then the tone stays ended with count held
  // - short tone with fade in and fade out, wide values with junk upper bits,
  //   restart after the end
  // - fade longer than the tone, so only fade-in applies, all-ones phase step
  initial begin
    dir_tab = '{
      '{ROW_WORD, '0, '0, 1'b0, 1'b1, '{16'sd0, 1'b0, 1'b1}},
      '{ROW_WORD, '0, '0, 1'b1, 1'b1, '{16'sd0, 1'b0, 1'b1}},
      '{ROW_REG, REG_PHASE_STEP, 32'h4000_0000, 1'b0, 1'b0, '0},
      '{ROW_REG, REG_VOLUME,     32'h0000_7FFF, 1'b0, 1'b0, '0},
      '{ROW_REG, REG_TOTAL,      32'h0000_0004, 1'b0, 1'b0, '0},
      '{ROW_REG, REG_FADE,       32'h0000_0000, 1'b0, 1'b0, '0},
      '{ROW_REG, REG_SPARE,      32'hDEAD_BEEF, 1'b0, 1'b0, '0},
      '{ROW_WORD, '0, '0, 1'b1, 1'b1, '{16'sd0, 1'b0, 1'b0}},
      '{ROW_WORD, '0, '0, 1'b0, 1'b1, '{16'sd32766, 1'b0, 1'b0}},
      '{ROW_WORD, '0, '0, 1'b0, 1'b1, '{16'sd0, 1'b0, 1'b0}},
      '{ROW_WORD, '0, '0, 1'b0, 1'b1, '{-16'sd32766, 1'b1, 1'b0}},
      '{ROW_WORD, '0, '0, 1'b0, 1'b1, '{16'sd0, 1'b0, 1'b1}},
      '{ROW_WORD, '0, '0, 1'b0, 1'b1, '{16'sd0, 1'b0, 1'b1}},
      '{ROW_REG, REG_PHASE_STEP, 32'h0123_4567, 1'b0, 1'b0, '0},
      '{ROW_REG, REG_VOLUME,     32'hFFFF_CE20, 1'b0, 1'b0, '0},
      '{ROW_REG, REG_TOTAL,      32'hABCD_000A, 1'b0, 1'b0, '0},
      '{ROW_REG, REG_FADE,       32'h0000_0003, 1'b0, 1'b0, '0},
      '{ROW_WORD, '0, '0, 1'b1, 1'b0, '0},
      '{ROW_WORD, '0, '0, 1'b0, 1'b0, '0},
      '{ROW_WORD, '0, '0, 1'b0, 1'b0, '0},
      '{ROW_WORD, '0, '0, 1'b0, 1'b0, '0},
      '{ROW_WORD, '0, '0, 1'b0, 1'b0, '0},
      '{ROW_WORD, '0, '0, 1'b0, 1'b0, '0},
      '{ROW_WORD, '0, '0, 1'b0, 1'b0, '0},
      '{ROW_WORD, '0, '0, 1'b0, 1'b0, '0},
      '{ROW_WORD, '0, '0, 1'b0, 1'b0, '0},
      '{ROW_WORD, '0, '0, 1'b0, 1'b0, '0},
      '{ROW_WORD, '0, '0, 1'b0, 1'b0, '0},
      '{ROW_WORD, '0, '0, 1'b1, 1'b0, '0},
      '{ROW_WORD, '0, '0, 1'b0, 1'b0, '0},
      '{ROW_REG, REG_PHASE_STEP, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
      '{ROW_REG, REG_VOLUME,     32'h0000_7FFF, 1'b0, 1'b0, '0},
      '{ROW_REG, REG_TOTAL,      32'h0000_0005, 1'b0, 1'b0, '0},
      '{ROW_REG, REG_FADE,       32'h0000_0008, 1'b0, 1'b0, '0},
      '{ROW_WORD, '0, '0, 1'b1, 1'b0, '0},
      '{ROW_WORD, '0, '0, 1'b0, 1'b0, '0},
      '{ROW_WORD, '0, '0, 1'b0, 1'b0, '0},
      '{ROW_WORD, '0, '0, 1'b0, 1'b0, '0}
    };
  end

  // stimulus: reset, directed table, then randomized tones
  initial begin : stimulus
    int unsigned words_sent;
    int unsigned len;
    int unsigned vol;
    int unsigned tot;
    int unsigned fd;
    logic [31:0] step_val;
    logic [31:0] junk;
    in_if.valid   = 1'b0;
    in_if.restart = 1'b0;
    words_sent    = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_REG) begin
        // registers only change with nothing in flight
        drain();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_word(dir_tab[i].restart, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    // each pass is one tone: idle the block, program every register,
    // then a restart word and more words that play short tones out and long ones in part;
    // the drain at the top of each pass is also the full sender pause
    while (words_sent < RANDOM_WORDS) begin
      drain();
      quiet = ($urandom_range(0, 3) == 0);

      case ($urandom_range(0, 5))
        0:       step_val = 32'h0000_0000;
        1:       step_val = 32'hFFFF_FFFF;
        2:       step_val = 32'h4000_0000;
        default: step_val = $urandom;
      endcase
      case ($urandom_range(0, 4))
        0:       vol = 0;
        1:       vol = 32767;
        default: vol = $urandom_range(0, 32767);
      endcase
      // short tones mostly, so the end of the tone is reached often
      case ($urandom_range(0, 9))
        0:       tot = 0;
        1:       tot = 1;
        2:       tot = 65535;
        3:       tot = $urandom_range(1000, 65535);
        default: tot = $urandom_range(2, 40);
      endcase
      case ($urandom_range(0, 6))
        0:       fd = 0;
        1:       fd = 1;
        2:       fd = tot;
        3:       fd = (tot < 65535) ? tot + 1 : tot;
        4:       fd = 65535;
        default: fd = $urandom_range(0, tot / 2 + 1);
      endcase

      write_reg(REG_PHASE_STEP, step_val);
      // upper bits carry junk half of the time
      junk = $urandom_range(0, 1) ? $urandom : 32'h0;
      write_reg(REG_VOLUME, {junk[31:15], vol[14:0]});
      junk = $urandom_range(0, 1) ? $urandom : 32'h0;
      write_reg(REG_TOTAL, {junk[31:16], tot[15:0]});
      junk = $urandom_range(0, 1) ? $urandom : 32'h0;
      write_reg(REG_FADE, {junk[31:16], fd[15:0]});
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, $urandom);

      len = (tot <= 64) ? tot + 1 + $urandom_range(0, 4) : $urandom_range(20, 60);
      for (int unsigned n = 0; n < len; n++) begin
        // stray restarts mid-tone now and then
        send_word((n == 0) || ($urandom_range(0, 30) == 0), 1'b0, '0);
        words_sent++;
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_sine_tone_with_linear_fade_top: done, clean");
    end else begin
      $display("tb_sine_tone_with_linear_fade_top: done, errors");
    end
    $finish;
  end

  // sample sink: random stall before each word, compare against the oldest expectation
  initial begin : sample_sink
    int unsigned stall;
    tone_word_t  got;
    tone_word_t  want;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, MAX_WAIT);
      @(negedge clk_i);
      if (stall > 0) begin
        out_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready = 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
      got.sample   = out_if.sample;
      got.last     = out_if.last;
      got.finished = out_if.finished;
      if (pending_samples.size() == 0) begin
        $error("sample word with nothing expected: sample %0d last %0b finished %0b",
               got.sample, got.last, got.finished);
        mismatches++;
      end else begin
        want = pending_samples.pop_front();
        if (got.sample !== want.sample) begin
          $error("sample: expected %0d, got %0d", want.sample, got.sample);
          mismatches++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, got.last);
          mismatches++;
        end
        if (got.finished !== want.finished) begin
          $error("finished: expected %0b, got %0b", want.finished, got.finished);
          mismatches++;
        end
      end
    end
  end

  // watchdog against a hung handshake
  initial begin : watchdog
    #(WATCHDOG_CYCLES * CLK_PERIOD);
    $display("tb_sine_tone_with_linear_fade_top: done, errors");
    $finish;
  end

endmodule
